// ===== design/pfc_pkg.sv =====
// Shared types, codes and grid geometry for the Playfair digraph cipher unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package pfc_pkg;

   // Grid geometry and alphabet.
   localparam int GRID_SIDE   = 5;
   localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
   localparam int NUM_LETTERS = 26;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_idx_type;
   typedef logic [2:0] coord_type;
   typedef logic [2:0] action_type;
   typedef logic [1:0] status_code_type;

   localparam letter_type LETTER_I    = 5'd8;
   localparam letter_type LETTER_J    = 5'd9;
   localparam letter_type LETTER_LAST = 5'd25;

   // Action codes carried by a request transaction.
   localparam action_type ACT_BEGIN   = 3'd0;
   localparam action_type ACT_KEY     = 3'd1;
   localparam action_type ACT_FINISH  = 3'd2;
   localparam action_type ACT_ENCRYPT = 3'd3;
   localparam action_type ACT_DECRYPT = 3'd4;

   // Status codes returned with every response transaction.
   localparam status_code_type ST_OK           = 2'd0;
   localparam status_code_type ST_NOT_READY    = 2'd1;
   localparam status_code_type ST_AFTER_FINISH = 2'd2;

   typedef struct packed {
      action_type action;
      letter_type key_letter;
      letter_type first_letter;
      letter_type second_letter;
   } req_type;

   typedef struct packed {
      letter_type      out_first;
      letter_type      out_second;
      status_code_type status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic exec;
      logic fill_step;
      logic load_out;
   } pfc_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic fill_needed;
      logic fill_last;
      logic out_free;
   } pfc_stat_type;

   // Row of a row-major grid cell.
   function automatic coord_type row_of(input int k);
      return coord_type'(k / GRID_SIDE);
   endfunction

   // Column of a row-major grid cell.
   function automatic coord_type col_of(input int k);
      return coord_type'(k % GRID_SIDE);
   endfunction

   // Row-major cell index from a row and a column.
   function automatic cell_idx_type cell_index(input coord_type r, input coord_type c);
      int sum;
      sum = int'(r) * GRID_SIDE + int'(c);
      return cell_idx_type'(sum);
   endfunction

   // Move one place along a row or column with wraparound; back when reverse is set.
   function automatic coord_type wrap_step(input coord_type x, input logic reverse);
      coord_type res;
      if (reverse) begin
         res = (x == coord_type'(0)) ? coord_type'(GRID_SIDE - 1) : x - coord_type'(1);
      end else begin
         res = (x == coord_type'(GRID_SIDE - 1)) ? coord_type'(0) : x + coord_type'(1);
      end
      return res;
   endfunction

endpackage

// ===== design/pfc_datapath.sv =====
// Datapath of the Playfair unit: key grid, letter bookkeeping, position search,
// lookup memory and the response register. Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_datapath
   import pfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pfc_cmd_type  cmd,
   output pfc_stat_type stat,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   // Grid registers used for the parallel position search.
   letter_type grid_ff [GRID_CELLS];
   // Lookup copy of the grid, read at the two result cells.
   letter_type grid_mem [GRID_CELLS];

   req_type                  item_ff, item_in;
   logic [NUM_LETTERS-1:0]   used_ff, used_in;
   logic [4:0]               fill_ff, fill_in;
   logic                     complete_ff, complete_in;
   letter_type               letter_cnt_ff, letter_cnt_in;
   status_code_type          st_ff, st_in;
   logic                     cipher_ff, cipher_in;
   coord_type                row1_ff, row1_in, col1_ff, col1_in;
   coord_type                row2_ff, row2_in, col2_ff, col2_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic                     wr_en;
   letter_type               wr_letter;
   letter_type               first_key, second_key;
   coord_type                row1_s, col1_s, row2_s, col2_s;
   logic                     key_ok, fill_ok, reverse;
   cell_idx_type             idx1, idx2;

   // Digraph letters with j folded onto i.
   assign first_key  = (item_ff.first_letter == LETTER_J) ? LETTER_I : item_ff.first_letter;
   assign second_key = (item_ff.second_letter == LETTER_J) ? LETTER_I : item_ff.second_letter;

   // Parallel search of both letters over all grid cells; no match means the corner cell.
   always_comb begin
      row1_s = '0;
      col1_s = '0;
      row2_s = '0;
      col2_s = '0;
      for (int k = 0; k < GRID_CELLS; k++) begin
         if (grid_ff[k] == first_key) begin
            row1_s = row_of(k);
            col1_s = col_of(k);
         end
         if (grid_ff[k] == second_key) begin
            row2_s = row_of(k);
            col2_s = col_of(k);
         end
      end
   end

   // A key letter is placed when it is a real letter other than j and not yet used.
   assign key_ok = (item_ff.key_letter <= LETTER_LAST) && (item_ff.key_letter != LETTER_J)
                   && !used_ff[item_ff.key_letter] && (fill_ff < 5'(GRID_CELLS));
   // During the fill sweep the current letter is placed when unused and not j.
   assign fill_ok = (letter_cnt_ff != LETTER_J) && !used_ff[letter_cnt_ff]
                    && (fill_ff < 5'(GRID_CELLS));

   // Next state of the key bookkeeping and the working registers.
   always_comb begin
      item_in       = item_ff;
      used_in       = used_ff;
      fill_in       = fill_ff;
      complete_in   = complete_ff;
      letter_cnt_in = letter_cnt_ff;
      st_in         = st_ff;
      cipher_in     = cipher_ff;
      row1_in       = row1_ff;
      col1_in       = col1_ff;
      row2_in       = row2_ff;
      col2_in       = col2_ff;
      wr_en         = 1'b0;
      wr_letter     = item_ff.key_letter;

      if (cmd.take_item) begin
         item_in = req_data;
      end

      if (cmd.exec) begin
         st_in     = ST_OK;
         cipher_in = 1'b0;
         case (item_ff.action)
            ACT_BEGIN: begin
               used_in     = '0;
               fill_in     = '0;
               complete_in = 1'b0;
            end
            ACT_KEY: begin
               if (complete_ff) begin
                  st_in = ST_AFTER_FINISH;
               end else if (key_ok) begin
                  wr_en = 1'b1;
               end
            end
            ACT_FINISH: begin
               if (complete_ff) begin
                  st_in = ST_AFTER_FINISH;
               end else begin
                  letter_cnt_in = '0;
               end
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
               if (!complete_ff) begin
                  st_in = ST_NOT_READY;
               end else begin
                  cipher_in = 1'b1;
                  row1_in   = row1_s;
                  col1_in   = col1_s;
                  row2_in   = row2_s;
                  col2_in   = col2_s;
               end
            end
            default: begin
               st_in = ST_OK;
            end
         endcase
      end

      // One letter of the alphabet per cycle while finishing the key.
      if (cmd.fill_step) begin
         wr_letter     = letter_cnt_ff;
         wr_en         = fill_ok;
         letter_cnt_in = letter_cnt_ff + 5'd1;
         if (letter_cnt_ff == LETTER_LAST) begin
            complete_in = 1'b1;
         end
      end

      if (wr_en) begin
         used_in[wr_letter] = 1'b1;
         fill_in            = fill_ff + 5'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         fill_ff     <= '0;
         complete_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         fill_ff     <= fill_in;
         complete_ff <= complete_in;
      end
   end

   // Working registers; no reset needed.
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      letter_cnt_ff <= letter_cnt_in;
      st_ff         <= st_in;
      cipher_ff     <= cipher_in;
      row1_ff       <= row1_in;
      col1_ff       <= col1_in;
      row2_ff       <= row2_in;
      col2_ff       <= col2_in;
   end

   // Grid writes go to both the search registers and the lookup memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[fill_ff]  <= wr_letter;
         grid_mem[fill_ff] <= wr_letter;
      end
   end

   // Result cells: row shift, column shift, or rectangle swap of columns.
   assign reverse = (item_ff.action == ACT_DECRYPT);

   always_comb begin
      if (row1_ff == row2_ff) begin
         idx1 = cell_index(row1_ff, wrap_step(col1_ff, reverse));
         idx2 = cell_index(row2_ff, wrap_step(col2_ff, reverse));
      end else if (col1_ff == col2_ff) begin
         idx1 = cell_index(wrap_step(row1_ff, reverse), col1_ff);
         idx2 = cell_index(wrap_step(row2_ff, reverse), col2_ff);
      end else begin
         idx1 = cell_index(row1_ff, col2_ff);
         idx2 = cell_index(row2_ff, col1_ff);
      end
   end

   // Response register, loaded from the lookup memory when it is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.out_first  <= cipher_ff ? grid_mem[idx1] : '0;
         rsp_ff.out_second <= cipher_ff ? grid_mem[idx2] : '0;
         rsp_ff.status     <= st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.fill_needed = (item_ff.action == ACT_FINISH) && !complete_ff;
   assign stat.fill_last   = (letter_cnt_ff == LETTER_LAST);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 5'(GRID_CELLS))
      else $error("Grid fill count exceeds the grid size.");

   a_used_matches_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(fill_ff))
      else $error("Used-letter bits disagree with the fill count.");

   a_complete_full: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> fill_ff == 5'(GRID_CELLS))
      else $error("Grid marked complete without all cells written.");

   a_no_j_written: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_letter != LETTER_J) && (wr_letter <= LETTER_LAST))
      else $error("Illegal letter written into the grid.");
`endif

endmodule

// ===== design/pfc_ctrl.sv =====
// Controller of the Playfair unit: sequences accept, execute, key fill and response.
// Depends on pfc_pkg; drives the datapath by command signals.
`timescale 1ns / 1ps

module pfc_ctrl
   import pfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pfc_stat_type stat,
   output pfc_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_EXEC    = 4'b0010,
      S_FILL    = 4'b0100,
      S_RESPOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      can_take;
   logic      respond_done;

   // A new transaction is taken when idle, or in the cycle the previous result is loaded.
   assign respond_done = (state_ff == S_RESPOND) && stat.out_free;
   assign can_take     = (state_ff == S_IDLE) || respond_done;
   assign req_stall    = !can_take;

   assign cmd.take_item = can_take && req_valid;
   assign cmd.exec      = (state_ff == S_EXEC);
   assign cmd.fill_step = (state_ff == S_FILL);
   assign cmd.load_out  = respond_done;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = stat.fill_needed ? S_FILL : S_RESPOND;
         end
         S_FILL: begin
            if (stat.fill_last) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (stat.out_free) begin
               state_in = req_valid ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/playfair_digraph_cipher_unit.sv =====
// Top level of the Playfair digraph cipher unit.
// Joins pfc_ctrl and pfc_datapath; depends on pfc_pkg.
`timescale 1ns / 1ps

// Usage:
// The request channel (req_valid, req_stall, req_data) carries one action per
// transaction: begin key, key letter, finish key, encrypt pair or decrypt pair.
// The response channel (rsp_valid, rsp_stall, rsp_data) returns exactly one
// result per request: two letters and a status code.
// A transaction is taken at a clock edge with valid high and stall low.
// A taken request is registered, then executed, then its result enters the output register.
// A finish-key request adds a sweep over the alphabet that fills the
// rest of the grid, one letter per cycle.
// A request is not taken while the previous one is in its execute or fill step,
// so the finish sweep holds off the next request until the sweep ends.
// The next request is taken in the same cycle the previous result enters the
// output register, so a waiting result does not block a new request.
// When the receiver stalls, the result is held in the output register and the
// unit stops taking requests once its next result is ready.
// Reset (synchronous, active high) clears the key state: any cipher request
// then returns the not-ready status until a key is loaded and finished.

module playfair_digraph_cipher_unit
   import pfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   pfc_cmd_type  cmd;
   pfc_stat_type stat;

   pfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_playfair_digraph_cipher_unit.sv =====
// Self-checking testbench for the Playfair digraph cipher unit.
// Predicts each result from its own copy of the key grid and checks it; depends on pfc_pkg.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher_unit;
   import pfc_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_REPORTS  = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 375;
   localparam int DRAIN_CYCLES = 40;

   // Tracks the key grid as the unit should build it and queues the expected results.
   class digraph_scoreboard;
      letter_type             grid[GRID_CELLS];
      logic [NUM_LETTERS-1:0] used;
      int unsigned            fill_count;
      bit                     complete;
      rsp_type                awaited_rsp_q[$];
      int unsigned            errors;
      int unsigned            checked;
      int unsigned            not_ready_seen;
      int unsigned            after_finish_seen;
      int unsigned            encrypts;
      int unsigned            decrypts;

      function new();
         foreach (grid[k]) grid[k] = '0;
         used       = '0;
         fill_count = 0;
         complete   = 1'b0;
         errors     = 0;
         checked    = 0;
      endfunction

      // Appends one letter to the grid while there is room.
      function void place(letter_type l);
         if (fill_count < GRID_CELLS) begin
            grid[fill_count] = l;
            used[l]          = 1'b1;
            fill_count++;
         end
      endfunction

      // Row and column of a letter; a letter that is not found sits at the top left.
      function void find_cell(letter_type l, output int r, output int c);
         r = 0;
         c = 0;
         for (int k = 0; k < GRID_CELLS; k++) begin
            if (grid[k] == l) begin
               r = k / GRID_SIDE;
               c = k % GRID_SIDE;
            end
         end
      endfunction

      function letter_type letter_at(int r, int c);
         return grid[(r % GRID_SIDE) * GRID_SIDE + (c % GRID_SIDE)];
      endfunction

      // Applies one request to the grid state and returns the result it should give.
      function rsp_type playfair_transform(req_type item);
         rsp_type    res;
         letter_type a;
         letter_type b;
         int         r1, c1, r2, c2, shift;
         res = '0;
         case (item.action)
            ACT_BEGIN: begin
               used       = '0;
               fill_count = 0;
               complete   = 1'b0;
            end
            ACT_KEY: begin
               if (complete) begin
                  res.status = ST_AFTER_FINISH;
               end else if (item.key_letter <= LETTER_LAST && item.key_letter != LETTER_J &&
                            !used[item.key_letter]) begin
                  place(item.key_letter);
               end
            end
            ACT_FINISH: begin
               if (complete) begin
                  res.status = ST_AFTER_FINISH;
               end else begin
                  for (int l = 0; l < NUM_LETTERS; l++) begin
                     if (letter_type'(l) != LETTER_J && !used[l]) place(letter_type'(l));
                  end
                  complete = 1'b1;
               end
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
               if (!complete) begin
                  res.status = ST_NOT_READY;
               end else begin
                  shift = (item.action == ACT_ENCRYPT) ? 1 : GRID_SIDE - 1;
                  a = (item.first_letter == LETTER_J) ? LETTER_I : item.first_letter;
                  b = (item.second_letter == LETTER_J) ? LETTER_I : item.second_letter;
                  find_cell(a, r1, c1);
                  find_cell(b, r2, c2);
                  if (r1 == r2) begin
                     res.out_first  = letter_at(r1, c1 + shift);
                     res.out_second = letter_at(r2, c2 + shift);
                  end else if (c1 == c2) begin
                     res.out_first  = letter_at(r1 + shift, c1);
                     res.out_second = letter_at(r2 + shift, c2);
                  end else begin
                     res.out_first  = letter_at(r1, c2);
                     res.out_second = letter_at(r2, c1);
                  end
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(req_type item);
         if (item.action == ACT_ENCRYPT) encrypts++;
         if (item.action == ACT_DECRYPT) decrypts++;
         awaited_rsp_q.push_back(playfair_transform(item));
      endfunction

      function void flag(string field, logic [7:0] want, logic [7:0] got);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: result with nothing awaited: expected none, actual %0d %0d %0d",
                        $time, got.out_first, got.out_second, got.status);
            end
            return;
         end
         want = awaited_rsp_q.pop_front();
         checked++;
         if (want.status == ST_NOT_READY) not_ready_seen++;
         if (want.status == ST_AFTER_FINISH) after_finish_seen++;
         if (got.out_first !== want.out_first) begin
            flag("out_first", 8'(want.out_first), 8'(got.out_first));
         end
         if (got.out_second !== want.out_second) begin
            flag("out_second", 8'(want.out_second), 8'(got.out_second));
         end
         if (got.status !== want.status) begin
            flag("status", 8'(want.status), 8'(got.status));
         end
      endfunction

      function int pending();
         return awaited_rsp_q.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   digraph_scoreboard board = new();
   int unsigned       cycle_count   = 0;
   int unsigned       items_sent    = 0;
   int unsigned       sessions      = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;
   bit                hold_off      = 1'b0;

   playfair_digraph_cipher_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, or a solid hold while a long hold-off is running.
   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   // Every accepted result transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // Hard stop in case the unit hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still awaited",
                  $time, cycle_count, board.pending());
         $display("tb_playfair_digraph_cipher_unit: errors");
         $finish;
      end
   end

   function automatic letter_type rand5();
      return letter_type'($urandom_range(31));
   endfunction

   // Mostly real letters, now and then a code above z.
   function automatic letter_type cipher_letter();
      if ($urandom_range(99) < 4) return letter_type'($urandom_range(31, 26));
      return letter_type'($urandom_range(25));
   endfunction

   // Key letters: mostly real letters, some j and some codes above z.
   function automatic letter_type key_pick();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return LETTER_J;
      if (roll < 10) return letter_type'($urandom_range(31, 26));
      return letter_type'($urandom_range(25));
   endfunction

   function automatic req_type make_req(action_type act, letter_type key, letter_type a,
                                        letter_type b);
      req_type item;
      item.action        = act;
      item.key_letter    = key;
      item.first_letter  = a;
      item.second_letter = b;
      return item;
   endfunction

   function automatic req_type cipher_req();
      letter_type a;
      a = cipher_letter();
      return make_req($urandom_range(1) ? ACT_ENCRYPT : ACT_DECRYPT, rand5(), a,
                      ($urandom_range(99) < 5) ? a : cipher_letter());
   endfunction

   // Offers one request transaction, starting and ending at a falling edge.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
      if (item.action <= ACT_DECRYPT) items_sent++;
      @(negedge clock);
   endtask

   // One key session: begin, key letters, finish, then a run of digraphs.
   // Some sessions skip the begin or the finish, or end with key input after finish.
   task automatic run_session();
      letter_type perm[GRID_CELLS];
      letter_type tmp;
      int         swap_idx;
      sessions++;
      if ($urandom_range(99) < 95) send_request(make_req(ACT_BEGIN, rand5(), rand5(), rand5()));
      if ($urandom_range(99) < 12) begin
         // Full key: all 25 letters in random order, so finish adds nothing.
         for (int k = 0; k < GRID_CELLS; k++) begin
            perm[k] = (k < LETTER_J) ? letter_type'(k) : letter_type'(k + 1);
         end
         for (int k = GRID_CELLS - 1; k > 0; k--) begin
            swap_idx       = $urandom_range(k);
            tmp            = perm[k];
            perm[k]        = perm[swap_idx];
            perm[swap_idx] = tmp;
         end
         for (int k = 0; k < GRID_CELLS; k++) begin
            send_request(make_req(ACT_KEY, perm[k], rand5(), rand5()));
         end
      end else begin
         repeat ($urandom_range(12)) send_request(make_req(ACT_KEY, key_pick(), rand5(), rand5()));
      end
      if ($urandom_range(99) < 90) send_request(make_req(ACT_FINISH, rand5(), rand5(), rand5()));
      repeat ($urandom_range(40, 4)) begin
         if ($urandom_range(99) < 6) begin
            send_request(make_req(action_type'($urandom_range(7)), rand5(), rand5(), rand5()));
         end else begin
            send_request(cipher_req());
         end
      end
      if ($urandom_range(99) < 10) begin
         send_request(make_req($urandom_range(1) ? ACT_KEY : ACT_FINISH, key_pick(), rand5(),
                               rand5()));
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_mix, input int target);
      int unsigned start;
      send_idle_pct = idle_pct;
      stall_pct     = stall_mix;
      start         = items_sent;
      while (items_sent - start < target) run_session();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: ciphers before any key, then the key "monarch" with a skipped j,
      // a repeated letter and a code above z, then row and rectangle digraphs and the error cases.
      send_request(make_req(ACT_ENCRYPT, 5'd0, 5'd0, 5'd1));
      send_request(make_req(ACT_DECRYPT, 5'd31, 5'd25, 5'd25));
      send_request(make_req(ACT_BEGIN, 5'd0, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd12, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd14, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd13, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd0, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd17, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd2, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd7, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, LETTER_J, 5'd0, 5'd0));
      send_request(make_req(ACT_KEY, 5'd0, 5'd31, 5'd31));
      send_request(make_req(ACT_KEY, 5'd31, 5'd0, 5'd0));
      send_request(make_req(ACT_FINISH, 5'd0, 5'd0, 5'd0));
      send_request(make_req(ACT_ENCRYPT, 5'd0, 5'd0, 5'd17));
      send_request(make_req(ACT_ENCRYPT, 5'd0, 5'd14, 5'd21));
      send_request(make_req(ACT_ENCRYPT, 5'd0, 5'd25, 5'd0));
      send_request(make_req(ACT_ENCRYPT, 5'd0, LETTER_J, 5'd10));
      send_request(make_req(ACT_ENCRYPT, 5'd0, 5'd11, 5'd11));
      send_request(make_req(ACT_ENCRYPT, 5'd0, 5'd31, 5'd26));
      send_request(make_req(ACT_DECRYPT, 5'd31, 5'd25, 5'd0));
      send_request(make_req(ACT_KEY, 5'd4, 5'd0, 5'd0));
      send_request(make_req(ACT_FINISH, 5'd0, 5'd0, 5'd0));
      send_request(make_req(action_type'(5), 5'd31, 5'd31, 5'd31));
      send_request(make_req(action_type'(6), 5'd21, 5'd10, 5'd5));
      send_request(make_req(action_type'(7), 5'd10, 5'd21, 5'd26));

      // Random sessions under each idling mix.
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(63, 0, PHASE_ITEMS);
      run_phase(0, 63, PHASE_ITEMS);

      // Long receiver hold-off while the sender keeps offering, to back up the unit.
      send_idle_pct = 0;
      stall_pct     = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (2) run_session();
      join

      run_phase(35, 35, PHASE_ITEMS);
      req_valid <= 1'b0;

      // Drain, then give the unit time to show any stray result.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests in %0d key sessions (%0d encrypt, %0d decrypt)",
               items_sent, sessions, board.encrypts, board.decrypts);
      $display("under four idle mixes and a long receiver hold; checked %0d results, %0d %s",
               board.checked, board.not_ready_seen, "not-ready,");
      $display("and %0d after-finish.", board.after_finish_seen);
      if (board.errors == 0) begin
         $display("tb_playfair_digraph_cipher_unit: clean");
      end else begin
         $display("tb_playfair_digraph_cipher_unit: errors");
      end
      $finish;
   end

endmodule
